/* rtl/etp_pkg.sv */
// shared constants, types and helper functions of the encoder to point transform
`default_nettype none
package etp_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int FRAC_BITS   = ANGLE_BITS - 2;
  localparam int MOD_STEPS   = 32;
  localparam int PH_LAT      = 1 + MOD_STEPS + 1 + ANGLE_BITS;
  localparam int TERMS       = 7;
  localparam int SIN_TERMS   = 6;
  localparam int SC_LAT      = 4 + 3 * TERMS + 1;
  localparam int RECIP_SHIFT = 34;
  localparam int NCNT        = 6;

  localparam int IDX_GX  = 0;
  localparam int IDX_GY  = 1;
  localparam int IDX_GZ  = 2;
  localparam int IDX_LOC = 3;
  localparam int IDX_SEN = 4;
  localparam int IDX_VAL = 5;

  localparam logic [30:0] HALF_PI_Q30 = 31'h6487ED51;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

  typedef logic signed [31:0] trig_t;
  typedef logic signed [47:0] q48_t;

  typedef enum logic [2:0] {
    REG_GLOBAL_STEP     = 3'd0,
    REG_ROTATION_LENGTH = 3'd1,
    REG_LOCAL_STEP      = 3'd2,
    REG_SENSOR_STEP     = 3'd3,
    REG_SENSOR_RES      = 3'd4
  } reg_idx_t;

  function automatic int sin_div(int k);
    return (2 * k) * (2 * k + 1);
  endfunction

  function automatic int cos_div(int k);
    return (2 * k - 1) * (2 * k);
  endfunction

  function automatic q48_t sat48(logic signed [65:0] v);
    if (v > 66'(MAX48)) begin
      return MAX48;
    end else if (v < 66'(MIN48)) begin
      return MIN48;
    end
    return v[47:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/etp_phase.sv */
// rotation count reduction and phase division, one quotient bit per stage
`default_nettype none
module etp_phase (
  input  logic                            clk,
  input  logic                            en,
  input  logic [31:0]                     rot,
  input  logic [31:0]                     len,
  output logic [etp_pkg::ANGLE_BITS-1:0]  phase
);
  import etp_pkg::*;

  logic [31:0]           rem_r  [0:MOD_STEPS];
  logic [31:0]           dv_r   [0:MOD_STEPS];
  logic                  neg_r  [0:MOD_STEPS];
  logic [31:0]           pr_r   [0:ANGLE_BITS];
  logic [ANGLE_BITS-1:0] q_r    [0:ANGLE_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      dv_r[0]  <= rot[31] ? 32'(-rot) : rot;
      neg_r[0] <= rot[31];
    end
  end

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    logic [32:0] t;
    assign t = {rem_r[j], dv_r[j][31]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= (t >= {1'b0, len}) ? 32'(t - {1'b0, len}) : t[31:0];
        dv_r[j+1]  <= {dv_r[j][30:0], 1'b0};
        neg_r[j+1] <= neg_r[j];
      end
    end
  end

  // negative counts wrap to the non-negative residue
  always_ff @(posedge clk) begin
    if (en) begin
      pr_r[0] <= (neg_r[MOD_STEPS] && (rem_r[MOD_STEPS] != '0)) ?
                 32'(len - rem_r[MOD_STEPS]) : rem_r[MOD_STEPS];
      q_r[0]  <= '0;
    end
  end

  for (genvar j = 0; j < ANGLE_BITS; j++) begin : g_div
    logic [32:0] t;
    logic        ge;
    assign t  = {pr_r[j], 1'b0};
    assign ge = (t >= {1'b0, len});
    always_ff @(posedge clk) begin
      if (en) begin
        pr_r[j+1] <= ge ? 32'(t - {1'b0, len}) : t[31:0];
        q_r[j+1]  <= {q_r[j][ANGLE_BITS-2:0], ge};
      end
    end
  end

  assign phase = q_r[ANGLE_BITS];

endmodule
`default_nettype wire

/* rtl/etp_sincos.sv */
// pipelined fixed point sine and cosine by taylor series, three stages per term
`default_nettype none
module etp_sincos (
  input  logic                            clk,
  input  logic                            en,
  input  logic [etp_pkg::ANGLE_BITS-1:0]  phase,
  input  logic                            zero_len,
  output etp_pkg::trig_t                  sn,
  output etp_pkg::trig_t                  cs
);
  import etp_pkg::*;

  logic [60:0]        xp_r;
  logic [1:0]         q0_r, q1_r, q2_r;
  logic [30:0]        x_r, xd_r;
  logic [61:0]        x2p_r;
  logic [31:0]        x2_r [0:TERMS];
  logic [31:0]        st_r [0:TERMS];
  logic [31:0]        ct_r [0:TERMS];
  logic signed [33:0] sa_r [0:TERMS];
  logic signed [33:0] ca_r [0:TERMS];
  logic [1:0]         qd_r [0:TERMS];
  trig_t              sn_r, cs_r;
  logic [30:0]        ss_c, cc_c;
  logic [29:0]        f;

  assign f = {phase[FRAC_BITS-1:0], (30 - FRAC_BITS)'(0)};

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r     <= 61'(f) * 61'(HALF_PI_Q30);
      q0_r     <= phase[ANGLE_BITS-1:ANGLE_BITS-2];
      x_r      <= xp_r[60:30];
      x2p_r    <= 62'(x_r) * 62'(x_r);
      xd_r     <= x_r;
      q1_r     <= q0_r;
      q2_r     <= q1_r;
      x2_r[0]  <= x2p_r[61:30];
      st_r[0]  <= {1'b0, xd_r};
      ct_r[0]  <= 32'(ONE_Q30);
      sa_r[0]  <= signed'({3'b000, xd_r});
      ca_r[0]  <= 34'(ONE_Q30);
      qd_r[0]  <= q2_r;
    end
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    localparam int SD = sin_div(k + 1);
    localparam int CD = cos_div(k + 1);
    localparam logic [34:0] SM = 35'((64'd1 << RECIP_SHIFT) / SD);
    localparam logic [34:0] CM = 35'((64'd1 << RECIP_SHIFT) / CD);

    logic [63:0]        sp_r, cp_r;
    logic [31:0]        x2a_r, x2b_r;
    logic signed [33:0] saa_r, caa_r, sab_r, cab_r;
    logic [1:0]         qa_r, qb_r;
    logic [33:0]        sq_r, cq_r;
    logic [68:0]        se_r, ce_r;
    logic [33:0]        s_est, c_est, s_rem, c_rem, s_new, c_new;

    always_ff @(posedge clk) begin
      if (en) begin
        sp_r  <= 64'(st_r[k]) * 64'(x2_r[k]);
        cp_r  <= 64'(ct_r[k]) * 64'(x2_r[k]);
        x2a_r <= x2_r[k];
        saa_r <= sa_r[k];
        caa_r <= ca_r[k];
        qa_r  <= qd_r[k];
        sq_r  <= sp_r[63:30];
        cq_r  <= cp_r[63:30];
        se_r  <= 69'(sp_r[63:30]) * 69'(SM);
        ce_r  <= 69'(cp_r[63:30]) * 69'(CM);
        x2b_r <= x2a_r;
        sab_r <= saa_r;
        cab_r <= caa_r;
        qb_r  <= qa_r;
      end
    end

    // reciprocal estimate is low by at most one
    assign s_est = se_r[67:34];
    assign c_est = ce_r[67:34];
    assign s_rem = sq_r - 34'(s_est * 34'(SD));
    assign c_rem = cq_r - 34'(c_est * 34'(CD));
    assign s_new = s_est + ((s_rem >= 34'(SD)) ? 34'd1 : 34'd0);
    assign c_new = c_est + ((c_rem >= 34'(CD)) ? 34'd1 : 34'd0);

    always_ff @(posedge clk) begin
      if (en) begin
        x2_r[k+1] <= x2b_r;
        qd_r[k+1] <= qb_r;
        ct_r[k+1] <= c_new[31:0];
        if (k % 2 == 0) begin
          ca_r[k+1] <= cab_r - signed'({2'b00, c_new[31:0]});
        end else begin
          ca_r[k+1] <= cab_r + signed'({2'b00, c_new[31:0]});
        end
        if (k < SIN_TERMS) begin
          st_r[k+1] <= s_new[31:0];
          if (k % 2 == 0) begin
            sa_r[k+1] <= sab_r - signed'({2'b00, s_new[31:0]});
          end else begin
            sa_r[k+1] <= sab_r + signed'({2'b00, s_new[31:0]});
          end
        end else begin
          st_r[k+1] <= st_r[k];
          sa_r[k+1] <= sab_r;
        end
      end
    end
  end

  always_comb begin
    if (sa_r[TERMS] < 0) begin
      ss_c = '0;
    end else if (sa_r[TERMS] > 34'(ONE_Q30)) begin
      ss_c = 31'(ONE_Q30);
    end else begin
      ss_c = sa_r[TERMS][30:0];
    end
    if (ca_r[TERMS] < 0) begin
      cc_c = '0;
    end else if (ca_r[TERMS] > 34'(ONE_Q30)) begin
      cc_c = 31'(ONE_Q30);
    end else begin
      cc_c = ca_r[TERMS][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_len) begin
        sn_r <= '0;
        cs_r <= ONE_Q30;
      end else begin
        unique case (qd_r[TERMS])
          2'd0: begin
            sn_r <= signed'({1'b0, ss_c});
            cs_r <= signed'({1'b0, cc_c});
          end
          2'd1: begin
            sn_r <= signed'({1'b0, cc_c});
            cs_r <= -signed'({1'b0, ss_c});
          end
          2'd2: begin
            sn_r <= -signed'({1'b0, ss_c});
            cs_r <= -signed'({1'b0, cc_c});
          end
          default: begin
            sn_r <= -signed'({1'b0, cc_c});
            cs_r <= signed'({1'b0, ss_c});
          end
        endcase
      end
    end
  end

  assign sn = sn_r;
  assign cs = cs_r;

endmodule
`default_nettype wire

/* rtl/encoder_to_point_transform_top.sv */
// encoder to point transform: scaling, rotation about z and offset of one reading
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   seven 32-bit signed counts
//  out      output     out_valid/out_stall six 48-bit signed q32.16 coordinates
//  cfg      input      psel/penable/pready five 32-bit registers at 4*i
//
// one item per cycle, unless a stalled output freezes the pipeline
// its depth comes from the bit-per-stage residue and phase divider and the taylor stages
// rst_n clears the valid bits and loads the register defaults
// a stalled output freezes the whole pipeline; in_stall follows it in the same cycle
`default_nettype none
module encoder_to_point_transform_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_global_x_count,
  input  logic signed [31:0] in_global_y_count,
  input  logic signed [31:0] in_global_z_count,
  input  logic signed [31:0] in_rotation_count,
  input  logic signed [31:0] in_local_count,
  input  logic signed [31:0] in_sensor_count,
  input  logic signed [31:0] in_sensor_value,
  output logic               out_valid,
  input  logic               out_stall,
  output etp_pkg::q48_t      out_surface_x,
  output etp_pkg::q48_t      out_surface_y,
  output etp_pkg::q48_t      out_surface_z,
  output etp_pkg::q48_t      out_probe_x,
  output etp_pkg::q48_t      out_probe_y,
  output etp_pkg::q48_t      out_probe_z
);
  import etp_pkg::*;

  localparam int D   = PH_LAT + SC_LAT;
  localparam int TOT = D + 8;

  logic [31:0] global_step_r, rotation_length_r, local_step_r, sensor_step_r;
  logic [31:0] sensor_resolution_r;
  logic [TOT-1:0] vld_r;
  logic en;
  logic [ANGLE_BITS-1:0] ph;
  trig_t sc_sn, sc_cs;

  logic [31:0] cd_r [0:D-1][0:NCNT-1];
  logic [31:0] mag1_r [0:NCNT-1];
  logic        neg1_r [0:NCNT-1];
  logic [63:0] prod2_r [0:NCNT-1];
  logic        neg2_r [0:NCNT-1];
  logic signed [63:0] val3_r [0:NCNT-1];
  trig_t sn1_r, cs1_r, sn2_r, cs2_r, sn3_r, cs3_r, sn4_r, cs4_r;
  q48_t  as4_r, ap4_r, b4_r;
  logic signed [63:0] g4_r [0:2];
  logic signed [63:0] g5_r [0:2];
  logic signed [63:0] g6_r [0:2];
  logic signed [63:0] g7_r [0:2];
  q48_t  opa [0:5];
  trig_t opc [0:5];
  logic [54:0] hp5_r [0:5];
  logic [54:0] lp5_r [0:5];
  logic        ng5_r [0:5];
  logic signed [49:0] pr6_r [0:5];
  logic signed [50:0] rxs7_r, rys7_r, rxp7_r, ryp7_r;
  q48_t sx_r, sy_r, sz_r, px_r, py_r, pz_r;
  logic [31:0] step_sel [0:NCNT-1];

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_step_r       <= 32'd65536;
      rotation_length_r   <= 32'd4096;
      local_step_r        <= 32'd65536;
      sensor_step_r       <= 32'd65536;
      sensor_resolution_r <= 32'd65536;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_GLOBAL_STEP:     global_step_r       <= pwdata;
        REG_ROTATION_LENGTH: rotation_length_r   <= pwdata;
        REG_LOCAL_STEP:      local_step_r        <= pwdata;
        REG_SENSOR_STEP:     sensor_step_r       <= pwdata;
        REG_SENSOR_RES:      sensor_resolution_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_GLOBAL_STEP:     prdata = global_step_r;
      REG_ROTATION_LENGTH: prdata = rotation_length_r;
      REG_LOCAL_STEP:      prdata = local_step_r;
      REG_SENSOR_STEP:     prdata = sensor_step_r;
      REG_SENSOR_RES:      prdata = sensor_resolution_r;
      default:             prdata = '0;
    endcase
  end

  // pipeline control
  assign en       = !(vld_r[TOT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_valid};
    end
  end

  etp_phase u_phase (
    .clk   (clk),
    .en    (en),
    .rot   (in_rotation_count),
    .len   (rotation_length_r),
    .phase (ph)
  );

  etp_sincos u_sincos (
    .clk      (clk),
    .en       (en),
    .phase    (ph),
    .zero_len (rotation_length_r == '0),
    .sn       (sc_sn),
    .cs       (sc_cs)
  );

  // counts wait for the angle
  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0][IDX_GX]  <= in_global_x_count;
      cd_r[0][IDX_GY]  <= in_global_y_count;
      cd_r[0][IDX_GZ]  <= in_global_z_count;
      cd_r[0][IDX_LOC] <= in_local_count;
      cd_r[0][IDX_SEN] <= in_sensor_count;
      cd_r[0][IDX_VAL] <= in_sensor_value;
      for (int i = 1; i < D; i++) begin
        cd_r[i] <= cd_r[i-1];
      end
    end
  end

  assign step_sel[IDX_GX]  = global_step_r;
  assign step_sel[IDX_GY]  = global_step_r;
  assign step_sel[IDX_GZ]  = global_step_r;
  assign step_sel[IDX_LOC] = local_step_r;
  assign step_sel[IDX_SEN] = sensor_step_r;
  assign step_sel[IDX_VAL] = sensor_resolution_r;

  // scaling of counts by steps
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NCNT; i++) begin
        mag1_r[i]  <= cd_r[D-1][i][31] ? 32'(-cd_r[D-1][i]) : cd_r[D-1][i];
        neg1_r[i]  <= cd_r[D-1][i][31];
        prod2_r[i] <= 64'(mag1_r[i]) * 64'(step_sel[i]);
        neg2_r[i]  <= neg1_r[i];
        val3_r[i]  <= neg2_r[i] ? -signed'(prod2_r[i]) : signed'(prod2_r[i]);
      end
      sn1_r <= sc_sn;
      cs1_r <= sc_cs;
      sn2_r <= sn1_r;
      cs2_r <= cs1_r;
      sn3_r <= sn2_r;
      cs3_r <= cs2_r;
      as4_r <= sat48(66'(val3_r[IDX_VAL]) + 66'(val3_r[IDX_LOC]));
      ap4_r <= sat48(66'(val3_r[IDX_LOC]));
      b4_r  <= sat48(66'(val3_r[IDX_SEN]));
      sn4_r <= sn3_r;
      cs4_r <= cs3_r;
      for (int i = 0; i < 3; i++) begin
        g4_r[i] <= val3_r[i];
        g5_r[i] <= g4_r[i];
        g6_r[i] <= g5_r[i];
        g7_r[i] <= g6_r[i];
      end
    end
  end

  // rotation products on magnitudes, split in two partial products
  always_comb begin
    opa[0] = as4_r; opc[0] = cs4_r;
    opa[1] = b4_r;  opc[1] = sn4_r;
    opa[2] = as4_r; opc[2] = sn4_r;
    opa[3] = b4_r;  opc[3] = cs4_r;
    opa[4] = ap4_r; opc[4] = cs4_r;
    opa[5] = ap4_r; opc[5] = sn4_r;
  end

  for (genvar i = 0; i < 6; i++) begin : g_mul
    logic [47:0] am;
    logic [30:0] cm;
    logic [78:0] sum;
    assign am  = opa[i][47] ? 48'(-opa[i]) : opa[i];
    assign cm  = opc[i][31] ? 31'(-opc[i]) : opc[i][30:0];
    assign sum = {hp5_r[i], 24'd0} + 79'(lp5_r[i]) + (79'd1 << 29);
    always_ff @(posedge clk) begin
      if (en) begin
        hp5_r[i] <= 55'(am[47:24]) * 55'(cm);
        lp5_r[i] <= 55'(am[23:0]) * 55'(cm);
        ng5_r[i] <= opa[i][47] ^ opc[i][31];
        pr6_r[i] <= ng5_r[i] ? -signed'({1'b0, sum[78:30]}) : signed'({1'b0, sum[78:30]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rxs7_r <= 51'(pr6_r[0]) - 51'(pr6_r[1]);
      rys7_r <= 51'(pr6_r[2]) + 51'(pr6_r[3]);
      rxp7_r <= 51'(pr6_r[4]) - 51'(pr6_r[1]);
      ryp7_r <= 51'(pr6_r[5]) + 51'(pr6_r[3]);
      sx_r   <= sat48(66'(g7_r[0]) + 66'(rxs7_r));
      sy_r   <= sat48(66'(g7_r[1]) + 66'(rys7_r));
      sz_r   <= sat48(66'(g7_r[2]));
      px_r   <= sat48(66'(g7_r[0]) + 66'(rxp7_r));
      py_r   <= sat48(66'(g7_r[1]) + 66'(ryp7_r));
      pz_r   <= sat48(66'(g7_r[2]));
    end
  end

  assign out_valid     = vld_r[TOT-1];
  assign out_surface_x = sx_r;
  assign out_surface_y = sy_r;
  assign out_surface_z = sz_r;
  assign out_probe_x   = px_r;
  assign out_probe_y   = py_r;
  assign out_probe_z   = pz_r;

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[D-1] |-> (sc_sn >= -ONE_Q30) && (sc_sn <= ONE_Q30) &&
                   (sc_cs >= -ONE_Q30) && (sc_cs <= ONE_Q30))
    else $error("sine or cosine out of range");

  a_same_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_surface_z == out_probe_z)
    else $error("surface and probe z differ");

endmodule
`default_nettype wire

/* bench/etp_checker.sv */
// checker for the encoder to point transform: predicts each point pair and compares
`timescale 1ns / 100ps
`default_nettype none
module etp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] gx_cnt,
  input  logic signed [31:0] gy_cnt,
  input  logic signed [31:0] gz_cnt,
  input  logic signed [31:0] rot_cnt,
  input  logic signed [31:0] loc_cnt,
  input  logic signed [31:0] sen_cnt,
  input  logic signed [31:0] sen_val,
  input  logic               out_valid,
  input  logic               out_stall,
  input  etp_pkg::q48_t      surf_x,
  input  etp_pkg::q48_t      surf_y,
  input  etp_pkg::q48_t      surf_z,
  input  etp_pkg::q48_t      prb_x,
  input  etp_pkg::q48_t      prb_y,
  input  etp_pkg::q48_t      prb_z,
  output int                 fail_count,
  output int                 pending
);
  import etp_pkg::*;

  typedef struct packed {
    q48_t sx, sy, sz, px, py, pz;
  } point_pair_t;

  localparam longint S64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64MIN = 64'sh8000_0000_0000_0000;
  localparam longint M48MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint M48MIN = 64'shFFFF_8000_0000_0000;

  logic [31:0] step_global, rot_len, step_local, step_sensor, sensor_res;
  point_pair_t point_q[$];

  function automatic longint scaled(logic signed [31:0] c, logic [31:0] st);
    longint cc;
    logic [63:0] mag;
    cc = c;
    mag = 64'(cc < 0 ? -cc : cc) * 64'(st);
    return cc < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > S64MAX - b) return S64MAX;
    if (b < 0 && a < S64MIN - b) return S64MIN;
    return a + b;
  endfunction

  function automatic longint clip48(longint v);
    if (v > M48MAX) return M48MAX;
    if (v < M48MIN) return M48MIN;
    return v;
  endfunction

  function automatic longint mul_trig(longint a, longint c);
    logic [63:0] am, cm, ah, al, hp, lo, r;
    am = a < 0 ? -a : a;
    cm = c < 0 ? -c : c;
    ah = am >> 24;
    al = am & 64'hFF_FFFF;
    hp = ah * cm;
    lo = ((hp & 64'd63) << 24) + al * cm + (64'd1 << 29);
    r = (hp >> 6) + (lo >> 30);
    return ((a < 0) != (c < 0)) ? -longint'(r) : longint'(r);
  endfunction

  task automatic trig_of(input logic [31:0] ph, output longint sv, output longint cv);
    logic [1:0] quad;
    logic [63:0] f, x, x2, term;
    longint ss, cc;
    quad = ph[ANGLE_BITS-1 -: 2];
    f = 64'(ph & ((32'd1 << (ANGLE_BITS - 2)) - 1)) << (32 - ANGLE_BITS);
    x = (f * 64'(HALF_PI_Q30)) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    ss = x;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      ss += (k % 2) ? -longint'(term) : longint'(term);
    end
    term = 64'd1 << 30;
    cc = 64'sd1 << 30;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      cc += (k % 2) ? -longint'(term) : longint'(term);
    end
    if (ss < 0) ss = 0;
    if (ss > (64'sd1 << 30)) ss = 64'sd1 << 30;
    if (cc < 0) cc = 0;
    if (cc > (64'sd1 << 30)) cc = 64'sd1 << 30;
    case (quad)
      2'd0: begin sv = ss; cv = cc; end
      2'd1: begin sv = cc; cv = -ss; end
      2'd2: begin sv = -ss; cv = -cc; end
      default: begin sv = -cc; cv = ss; end
    endcase
  endtask

  task automatic rotate_place(input longint gx, input longint gy, input longint a,
                              input longint b, input longint sn, input longint cs,
                              output q48_t ox, output q48_t oy);
    longint a48, b48;
    a48 = clip48(a);
    b48 = clip48(b);
    ox = q48_t'(clip48(add_sat(gx, mul_trig(a48, cs) - mul_trig(b48, sn))));
    oy = q48_t'(clip48(add_sat(gy, mul_trig(a48, sn) + mul_trig(b48, cs))));
  endtask

  task automatic predict_points;
    longint gx, gy, gz, lc, sc, range_len, rot, sn, cs;
    logic [63:0] len, m;
    logic [31:0] ph;
    point_pair_t p;
    gx = scaled(gx_cnt, step_global);
    gy = scaled(gy_cnt, step_global);
    gz = scaled(gz_cnt, step_global);
    lc = scaled(loc_cnt, step_local);
    sc = scaled(sen_cnt, step_sensor);
    range_len = scaled(sen_val, sensor_res);
    rot = rot_cnt;
    sn = 0;
    cs = 64'sd1 << 30;
    if (rot_len != 0) begin
      len = rot_len;
      if (rot >= 0) m = 64'(rot) % len;
      else m = (len - (64'(-rot) % len)) % len;
      ph = 32'((m << ANGLE_BITS) / len);
      trig_of(ph, sn, cs);
    end
    rotate_place(gx, gy, add_sat(range_len, lc), sc, sn, cs, p.sx, p.sy);
    rotate_place(gx, gy, lc, sc, sn, cs, p.px, p.py);
    p.sz = q48_t'(clip48(gz));
    p.pz = p.sz;
    point_q.push_back(p);
  endtask

  task automatic flag(input string what, input q48_t want, input q48_t got);
    if (fail_count < 10)
      $display("mismatch %s: expected %h actual %h", what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    point_pair_t e;
    if (!rst_n) begin
      step_global <= 32'd65536;
      rot_len <= 32'd4096;
      step_local <= 32'd65536;
      step_sensor <= 32'd65536;
      sensor_res <= 32'd65536;
      fail_count = 0;
      point_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_GLOBAL_STEP: step_global <= pwdata;
          REG_ROTATION_LENGTH: rot_len <= pwdata;
          REG_LOCAL_STEP: step_local <= pwdata;
          REG_SENSOR_STEP: step_sensor <= pwdata;
          REG_SENSOR_RES: sensor_res <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_points();
      if (out_valid && !out_stall) begin
        if (point_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected item out");
          fail_count++;
        end else begin
          e = point_q.pop_front();
          if (e.sx !== surf_x) flag("surface_x", e.sx, surf_x);
          if (e.sy !== surf_y) flag("surface_y", e.sy, surf_y);
          if (e.sz !== surf_z) flag("surface_z", e.sz, surf_z);
          if (e.px !== prb_x) flag("probe_x", e.px, prb_x);
          if (e.py !== prb_y) flag("probe_y", e.py, prb_y);
          if (e.pz !== prb_z) flag("probe_z", e.pz, prb_z);
        end
      end
    end
  end

  assign pending = point_q.size();
endmodule
`default_nettype wire

/* bench/tb.sv */
// testbench top for the encoder to point transform: stimulus, config writes and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import etp_pkg::*;

  localparam int LATENCY = 84;
  localparam int N_RANDOM = 1930;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] c_gx = '0, c_gy = '0, c_gz = '0, c_rot = '0;
  logic signed [31:0] c_loc = '0, c_sen = '0, c_val = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  q48_t sx, sy, sz, px, py, pz;
  int fail_count, pending;
  longint cycles = 0;
  bit hold_long = 1'b0;
  bit stim_done = 1'b0;

  always #6 clk = ~clk;

  encoder_to_point_transform_top i_dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall,
    .in_global_x_count(c_gx), .in_global_y_count(c_gy), .in_global_z_count(c_gz),
    .in_rotation_count(c_rot), .in_local_count(c_loc), .in_sensor_count(c_sen),
    .in_sensor_value(c_val),
    .out_valid, .out_stall,
    .out_surface_x(sx), .out_surface_y(sy), .out_surface_z(sz),
    .out_probe_x(px), .out_probe_y(py), .out_probe_z(pz)
  );

  etp_checker i_chk (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall,
    .gx_cnt(c_gx), .gy_cnt(c_gy), .gz_cnt(c_gz), .rot_cnt(c_rot),
    .loc_cnt(c_loc), .sen_cnt(c_sen), .sen_val(c_val),
    .out_valid, .out_stall,
    .surf_x(sx), .surf_y(sy), .surf_z(sz), .prb_x(px), .prb_y(py), .prb_z(pz),
    .fail_count, .pending
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] wild32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 40)) - 20);
      3: return $urandom_range(0, 200000);
      default: return $urandom;
    endcase
  endfunction

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send(input logic [31:0] gx, gy, gz, rot, loc, sen, val);
    repeat (gap_len() * $urandom_range(0, 1)) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    c_gx <= gx; c_gy <= gy; c_gz <= gz; c_rot <= rot;
    c_loc <= loc; c_sen <= sen; c_val <= val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic random_items(input int n);
    for (int i = 0; i < n; i++)
      send(wild32(), wild32(), wild32(), $urandom_range(0, 9) < 7 ? $urandom : wild32(),
           wild32(), wild32(), wild32());
  endtask

  // random receiver stalls, with one long hold-off at the start
  always @(negedge clk) begin
    if (hold_long) out_stall <= 1'b1;
    else if (stim_done) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 20) ? 1'b1 : 1'b0;
  end

  initial begin
    hold_long = 1'b1;
    repeat (LATENCY + 150) @(posedge clk);
    hold_long = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // extremes of every field (the rotation count only at its minimum) and the defaults
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h7FFF_FFFF);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h8000_0000);
    send(0, 0, 0, 32'd1024, 32'd5, 32'd3, 32'd7);
    send(0, 0, 0, 32'd2048, 32'd5, 32'd3, 32'd7);
    send(0, 0, 0, 32'd3072, 32'd5, 32'd3, 32'd7);
    send(0, 0, 0, 32'hFFFF_FC00, 32'd5, 32'd3, 32'd7);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
         32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'd4095, 32'hAAAA_AAAA,
         32'h5555_5555, 32'hAAAA_AAAA);
    random_items(600);
    drain();
    // zero rotation length and maximal steps
    reg_write(REG_ROTATION_LENGTH, 32'd0);
    reg_write(REG_GLOBAL_STEP, 32'hFFFF_FFFF);
    reg_write(REG_LOCAL_STEP, 32'hFFFF_FFFF);
    reg_write(REG_SENSOR_STEP, 32'hFFFF_FFFF);
    reg_write(REG_SENSOR_RES, 32'hFFFF_FFFF);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd77, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h7FFF_FFFF);
    random_items(300);
    drain();
    // zero steps, unit rotation length
    reg_write(REG_ROTATION_LENGTH, 32'd1);
    reg_write(REG_GLOBAL_STEP, 32'd0);
    reg_write(REG_LOCAL_STEP, 32'd0);
    reg_write(REG_SENSOR_STEP, 32'd0);
    reg_write(REG_SENSOR_RES, 32'd0);
    random_items(200);
    drain();
    // largest rotation length and odd steps
    reg_write(REG_ROTATION_LENGTH, 32'hFFFF_FFFF);
    reg_write(REG_GLOBAL_STEP, 32'd1);
    reg_write(REG_LOCAL_STEP, 32'h0001_8000);
    reg_write(REG_SENSOR_STEP, 32'h0000_4000);
    reg_write(REG_SENSOR_RES, 32'h0003_0000);
    send(0, 0, 0, 32'h7FFF_FFFF, 32'd100, 32'd100, 32'd100);
    send(0, 0, 0, 32'h8000_0000, 32'd100, 32'd100, 32'd100);
    random_items(400);
    drain();
    // random settings
    reg_write(REG_ROTATION_LENGTH, $urandom_range(2, 100000));
    reg_write(REG_GLOBAL_STEP, $urandom);
    reg_write(REG_LOCAL_STEP, $urandom_range(0, 32'h0010_0000));
    reg_write(REG_SENSOR_STEP, $urandom_range(0, 32'h0010_0000));
    reg_write(REG_SENSOR_RES, $urandom);
    random_items(N_RANDOM - 1500);
    @(negedge clk);
    in_valid <= 1'b0;
    stim_done = 1'b1;
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
